// File: src/atsch_pkg.sv
// package for the altitude tone schedule
// holds config indexes, reset values and the divider and sideband types
package atsch_pkg;

    localparam int unsigned DEFAULT_START_ALT = 1600;
    localparam int unsigned DEFAULT_FULL_ALT  = 800;

    localparam logic [15:0] START_RST      = 16'(DEFAULT_START_ALT);
    localparam logic [15:0] FULL_RST       = 16'(DEFAULT_FULL_ALT);
    localparam logic [15:0] FREQ_START_RST = 16'd4000;
    localparam logic [15:0] FREQ_GND_RST   = 16'd24000;
    localparam logic [15:0] CLAMP_LOW_RST  = 16'd4000;
    localparam logic [15:0] CLAMP_HIGH_RST = 16'd24000;
    localparam logic [15:0] FULL_LVL_RST   = 16'h0000;
    localparam logic [15:0] FLOOR_LVL_RST  = 16'hE200;
    localparam logic [15:0] SILENT_LEVEL   = 16'hB000;

    localparam int unsigned DIV_STEPS  = 4;
    localparam int unsigned DIV_STAGES = 16 / DIV_STEPS;
    // distance, product and load stages, divider slices, output register
    localparam int unsigned PIPE_DEPTH = DIV_STAGES + 4;

    typedef enum logic [2:0] {
        CFG_START_ALT  = 3'd0,
        CFG_FREQ_START = 3'd1,
        CFG_FREQ_GND   = 3'd2,
        CFG_CLAMP_LOW  = 3'd3,
        CFG_CLAMP_HIGH = 3'd4,
        CFG_FULL_LVL   = 3'd5,
        CFG_FLOOR_LVL  = 3'd6
    } t_cfg_idx;

    // partial remainder and dividend bits; quotient bits fill lo from the bottom
    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] lo;
    } t_div;

    typedef struct packed {
        logic neg_p;
        logic neg_l;
        logic above;
        logic in_full;
    } t_side;

endpackage

// File: src/atsch_div_stage.sv
// one registered slice of the restoring divider, DIV_STEPS quotient bits per slice
// depends on atsch_pkg
module atsch_div_stage (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [15:0]       i_den,
    input  atsch_pkg::t_div   i_d,
    output atsch_pkg::t_div   o_d
);
    import atsch_pkg::*;

    t_div r_d;
    t_div n_d;

    always_comb begin
        logic [16:0] t;
        n_d = i_d;
        for (int k = 0; k < int'(DIV_STEPS); k++) begin
            t = {n_d.rem, n_d.lo[15]};
            if (t >= {1'b0, i_den}) begin
                n_d.rem = 16'(t - {1'b0, i_den});
                n_d.lo  = {n_d.lo[14:0], 1'b1};
            end else begin
                n_d.rem = t[15:0];
                n_d.lo  = {n_d.lo[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// File: src/altitude_tone_schedule.sv
// top level of the altitude tone schedule: config registers and the pitch/level pipeline
// depends on atsch_pkg and atsch_div_stage
//
// usage: one altitude beat in on i_valid/o_ready, one result beat out on o_valid/i_ready.
// each beat gives a pitch glided linearly from freq_at_start to freq_at_ground and clamped
// to the band, a level ramp between floor and full level, and an above-band flag.
// a new beat is taken every cycle unless the output register holds a beat and i_ready is low.
// the pipeline is a distance stage, a multiply stage, a rounding stage, four divider slices of
// four quotient bits each, and an output register; the 16-step division sets the depth.
// when the receiver holds i_ready low the whole pipeline freezes and o_ready drops,
// unless the output register is empty, so no beat is lost or repeated. config writes
// (i_cfg_we, i_cfg_addr, i_cfg_data) take effect at once; the user must make them only while
// the pipeline is empty, which the block does not enforce. a start altitude at or below the
// default full altitude is replaced by the default start; the full altitude follows as half
// of it. synchronous active-low reset empties the pipeline and restores the register defaults.
module altitude_tone_schedule (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_altitude,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_tone_pitch,
    output logic signed [15:0] o_tone_level,
    output logic        o_above_band,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);
    import atsch_pkg::*;

    // config
    logic [15:0] r_start, r_full, r_den;
    logic [15:0] r_fs, r_fg, r_low, r_high, r_fu, r_fl;
    logic [15:0] n_start;

    assign n_start = (i_cfg_data > FULL_RST) ? i_cfg_data : START_RST;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_RST;
            r_full  <= FULL_RST;
            r_den   <= START_RST - FULL_RST;
            r_fs    <= FREQ_START_RST;
            r_fg    <= FREQ_GND_RST;
            r_low   <= CLAMP_LOW_RST;
            r_high  <= CLAMP_HIGH_RST;
            r_fu    <= FULL_LVL_RST;
            r_fl    <= FLOOR_LVL_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_START_ALT: begin
                    // default full altitude is exactly half the default start
                    r_start <= n_start;
                    r_full  <= {1'b0, n_start[15:1]};
                    r_den   <= n_start - {1'b0, n_start[15:1]};
                end
                CFG_FREQ_START: r_fs   <= i_cfg_data;
                CFG_FREQ_GND:   r_fg   <= i_cfg_data;
                CFG_CLAMP_LOW:  r_low  <= i_cfg_data;
                CFG_CLAMP_HIGH: r_high <= i_cfg_data;
                CFG_FULL_LVL:   r_fu   <= i_cfg_data;
                CFG_FLOOR_LVL:  r_fl   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic [PIPE_DEPTH-1:0] r_v;
    logic                  w_en;

    assign w_en    = !r_v[PIPE_DEPTH-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_v[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[PIPE_DEPTH-2:0], i_valid};
        end
    end

    // stage 0: distances and spans
    logic [15:0]        r0_dist_p, r0_dist_l;
    logic signed [16:0] r0_diff_p, r0_diff_l;
    logic               r0_above, r0_full;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_dist_p <= r_start - ((i_altitude < r_start) ? i_altitude : r_start);
            r0_dist_l <= r_start - i_altitude;
            r0_diff_p <= $signed({1'b0, r_fg}) - $signed({1'b0, r_fs});
            r0_diff_l <= $signed({r_fu[15], r_fu}) - $signed({r_fl[15], r_fl});
            r0_above  <= i_altitude > r_start;
            r0_full   <= i_altitude <= r_full;
        end
    end

    // stage 1: products
    logic signed [33:0] r1_prod_p, r1_prod_l;
    logic               r1_above, r1_full;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_prod_p <= $signed({1'b0, r0_dist_p}) * r0_diff_p;
            r1_prod_l <= $signed({1'b0, r0_dist_l}) * r0_diff_l;
            r1_above  <= r0_above;
            r1_full   <= r0_full;
        end
    end

    // stage 2: magnitude plus half divisor, loaded into the divider
    logic [33:0] w_mag_p, w_mag_l;
    logic [32:0] w_num_p, w_num_l;
    t_div        w_div_p [0:DIV_STAGES];
    t_div        w_div_l [0:DIV_STAGES];
    t_div        r2_div_p, r2_div_l;
    t_side       r_side [0:DIV_STAGES];

    assign w_mag_p = r1_prod_p[33] ? 34'(-r1_prod_p) : 34'(r1_prod_p);
    assign w_mag_l = r1_prod_l[33] ? 34'(-r1_prod_l) : 34'(r1_prod_l);
    assign w_num_p = 33'(w_mag_p[31:0]) + 33'({1'b0, r_start[15:1]});
    assign w_num_l = 33'(w_mag_l[31:0]) + 33'({1'b0, r_den[15:1]});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // top half is below the divisor, so the quotient fits 16 bits
            r2_div_p <= '{rem: w_num_p[31:16], lo: w_num_p[15:0]};
            r2_div_l <= '{rem: w_num_l[31:16], lo: w_num_l[15:0]};
            r_side[0] <= '{neg_p: r1_prod_p[33], neg_l: r1_prod_l[33],
                           above: r1_above, in_full: r1_full};
        end
    end

    assign w_div_p[0] = r2_div_p;
    assign w_div_l[0] = r2_div_l;

    for (genvar g = 0; g < int'(DIV_STAGES); g++) begin : g_div
        atsch_div_stage u_div_p (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_den (r_start),
            .i_d   (w_div_p[g]),
            .o_d   (w_div_p[g+1])
        );
        atsch_div_stage u_div_l (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_den (r_den),
            .i_d   (w_div_l[g]),
            .o_d   (w_div_l[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_side[g+1] <= r_side[g];
            end
        end
    end

    // output stage: sign, offset, clamp and level select
    t_side              w_s;
    logic [15:0]        w_qp, w_ql;
    logic signed [17:0] w_fp, w_lv;
    logic [15:0]        n_pitch, n_level;
    logic [15:0]        r_pitch, r_level;
    logic               r_above;

    assign w_s  = r_side[DIV_STAGES];
    assign w_qp = w_div_p[DIV_STAGES].lo;
    assign w_ql = w_div_l[DIV_STAGES].lo;
    assign w_fp = w_s.neg_p ? $signed({2'b00, r_fs}) - $signed({2'b00, w_qp})
                            : $signed({2'b00, r_fs}) + $signed({2'b00, w_qp});
    assign w_lv = w_s.neg_l ? $signed({{2{r_fl[15]}}, r_fl}) - $signed({2'b00, w_ql})
                            : $signed({{2{r_fl[15]}}, r_fl}) + $signed({2'b00, w_ql});

    always_comb begin
        if (w_fp < $signed({2'b00, r_low})) begin
            n_pitch = r_low;
        end else if (w_fp > $signed({2'b00, r_high})) begin
            n_pitch = r_high;
        end else begin
            n_pitch = w_fp[15:0];
        end
        if (w_s.above) begin
            n_level = SILENT_LEVEL;
        end else if (w_s.in_full) begin
            n_level = r_fu;
        end else begin
            n_level = w_lv[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pitch <= n_pitch;
            r_level <= n_level;
            r_above <= w_s.above;
        end
    end

    assign o_tone_pitch = r_pitch;
    assign o_tone_level = $signed(r_level);
    assign o_above_band = r_above;

endmodule

// File: dv/tb_top.sv
// testbench for altitude_tone_schedule: directed and random altitude beats, config phases
// depends on atsch_pkg and the block rtl; predicts pitch, level and above-band flag
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import atsch_pkg::*;

    typedef struct {
        logic [15:0] pitch;
        logic [15:0] level;
        logic        above;
    } t_tone;

    class t_tone_scoreboard;
        t_tone       pending[$];
        int unsigned mismatches;
        logic [15:0] start_alt, full_alt, f_start, f_gnd, c_low, c_high, lvl_full, lvl_floor;

        function new();
            mismatches = 0;
            start_alt = START_RST; full_alt = FULL_RST;
            f_start = FREQ_START_RST; f_gnd = FREQ_GND_RST;
            c_low = CLAMP_LOW_RST; c_high = CLAMP_HIGH_RST;
            lvl_full = FULL_LVL_RST; lvl_floor = FLOOR_LVL_RST;
        endfunction

        static function longint round_div(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            return (num < 0) ? -q : q;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [15:0] v);
            longint fa;
            case (idx)
                CFG_START_ALT: begin
                    start_alt = (v > DEFAULT_FULL_ALT) ? v : 16'(DEFAULT_START_ALT);
                    fa = longint'(DEFAULT_FULL_ALT) * start_alt / DEFAULT_START_ALT;
                    full_alt = (fa > 65535) ? 16'hFFFF : 16'(fa);
                end
                CFG_FREQ_START: f_start = v;
                CFG_FREQ_GND:   f_gnd = v;
                CFG_CLAMP_LOW:  c_low = v;
                CFG_CLAMP_HIGH: c_high = v;
                CFG_FULL_LVL:   lvl_full = v;
                CFG_FLOOR_LVL:  lvl_floor = v;
                default: ;
            endcase
        endfunction

        function void note_altitude(logic [15:0] alt);
            t_tone  r;
            longint a, f, fl, fu, lv;
            a = (alt < start_alt) ? alt : start_alt;
            // linear glide
            f = longint'(f_start) + round_div((longint'(start_alt) - a) *
                (longint'(f_gnd) - longint'(f_start)), longint'(start_alt));
            if (f < c_low) r.pitch = c_low;
            else if (f > c_high) r.pitch = c_high;
            else r.pitch = 16'(f);
            r.above = alt > start_alt;
            fl = longint'($signed(lvl_floor));
            fu = longint'($signed(lvl_full));
            if (r.above) lv = longint'($signed(SILENT_LEVEL));
            else if (alt <= full_alt) lv = fu;
            else lv = fl + round_div((longint'(start_alt) - alt) * (fu - fl),
                                     longint'(start_alt) - full_alt);
            r.level = 16'(lv);
            pending.push_back(r);
        endfunction

        function void check_result(logic [15:0] p, logic [15:0] l, logic ab);
            t_tone e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat p=%0d l=%0d", p, l);
                return;
            end
            e = pending.pop_front();
            if (p !== e.pitch || l !== e.level || ab !== e.above) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp p=%0d l=%0d a=%0b got p=%0d l=%0d a=%0b",
                             e.pitch, $signed(e.level), e.above, p, $signed(l), ab);
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready, o_above_band, i_cfg_we;
    logic [15:0] i_altitude, o_tone_pitch, i_cfg_data;
    logic signed [15:0] o_tone_level;
    logic [2:0]  i_cfg_addr;

    t_tone_scoreboard sb;
    int unsigned cycles;
    int unsigned hold_off;    // receiver stall length requested by the stimulus
    bit          no_idle;

    altitude_tone_schedule DUT (.*);

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: random stalls plus one long hold-off
    initial begin
        i_ready = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) sb.check_result(o_tone_pitch, o_tone_level, o_above_band);
            if (hold_off > 0) begin
                hold_off--;
                i_ready <= 0;
            end else
                i_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 28);
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 400000) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // valid stays up between back-to-back beats; it drops in idle cycles and in drain
    task automatic send_altitude(logic [15:0] alt);
        while (!no_idle && $urandom_range(99) < 28) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_altitude <= alt;
        do @(posedge i_clk); while (!(o_ready === 1'b1));
        sb.note_altitude(alt);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [15:0] v);
        i_cfg_we <= 1;
        i_cfg_addr <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.write_reg(idx, v);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_altitude();
        case ($urandom_range(5))
            0: return 16'($urandom);
            1: return 16'($urandom_range(sb.start_alt));
            2: return sb.start_alt + 16'($urandom_range(2)) - 16'd1;
            3: return sb.full_alt + 16'($urandom_range(2)) - 16'd1;
            4: return 16'($urandom_range(sb.start_alt, sb.full_alt));
            default: return 16'($urandom_range(3));
        endcase
    endfunction

    initial begin
        logic [15:0] alts[$];
        sb = new();
        hold_off = 0;
        no_idle = 0;
        i_rst_n = 0; i_valid = 0; i_altitude = 0;
        i_cfg_we = 0; i_cfg_addr = CFG_START_ALT; i_cfg_data = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset settings, field extremes, band edges
        alts = '{16'd0, 16'd1, 16'd799, 16'd800, 16'd801, 16'd1200, 16'd1599,
                 16'd1600, 16'd1601, 16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA};
        foreach (alts[k]) send_altitude(alts[k]);
        drain();

        // guard: start at the default full altitude is replaced
        write_cfg(CFG_START_ALT, 16'd800);
        send_altitude(16'd900);
        drain();
        // inverted band, extreme levels, zero start freq
        write_cfg(CFG_START_ALT, 16'hFFFF);
        write_cfg(CFG_FREQ_START, 16'd0);
        write_cfg(CFG_FREQ_GND, 16'hFFFF);
        write_cfg(CFG_CLAMP_LOW, 16'd30000);
        write_cfg(CFG_CLAMP_HIGH, 16'd20000);
        write_cfg(CFG_FULL_LVL, 16'h7FFF);
        write_cfg(CFG_FLOOR_LVL, 16'h8000);
        alts = '{16'd0, 16'd32767, 16'd40000, 16'hFFFE, 16'hFFFF, 16'd32768};
        foreach (alts[k]) send_altitude(alts[k]);
        drain();

        // random phases with random settings, first one unthrottled
        for (int ph = 0; ph < 7; ph++) begin
            write_cfg(CFG_START_ALT, (ph == 6) ? 16'd801 : 16'($urandom));
            write_cfg(CFG_FREQ_START, 16'($urandom));
            write_cfg(CFG_FREQ_GND, 16'($urandom));
            write_cfg(CFG_CLAMP_LOW, (ph % 2) ? 16'd0 : 16'($urandom_range(20000)));
            write_cfg(CFG_CLAMP_HIGH, (ph % 2) ? 16'hFFFF : 16'($urandom_range(65535, 20000)));
            write_cfg(CFG_FULL_LVL, 16'($urandom));
            write_cfg(CFG_FLOOR_LVL, 16'($urandom));
            no_idle = (ph == 0);
            for (int n = 0; n < 250; n++) begin
                if (ph == 2 && n == 50) hold_off = 200;
                send_altitude(pick_altitude());
            end
            // sender pauses until every result is back
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
